>>> src/sfte_pkg.sv
// Shared types and constants of the strip/fan triangle expander.
`default_nettype none

package sfte_pkg;

   localparam int INDEX_WIDTH = 15;
   localparam int FIELD_WIDTH = 16;
   localparam int INV_WIDTH   = 24;
   localparam int TEX_WIDTH   = 39;
   localparam int PROD_WIDTH  = FIELD_WIDTH + INV_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 2;

   // record kinds
   localparam logic ACTION_HEADER = 1'b0;
   localparam logic ACTION_VERTEX = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMAL_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_TEX_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_TEX_HEIGHT = 2'd3;

   localparam logic [INV_WIDTH-1:0] INV_TEX_RESET = 24'd131072;

   // triangle corner selects
   localparam logic [1:0] CORNER_FIRST  = 2'd0;
   localparam logic [1:0] CORNER_SECOND = 2'd1;
   localparam logic [1:0] CORNER_LAST   = 2'd2;

   localparam logic [TEX_WIDTH-1:0] TEX_MAX = {1'b0, {(TEX_WIDTH-1){1'b1}}};
   localparam logic [TEX_WIDTH-1:0] TEX_MIN = {1'b1, {(TEX_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] vi;
      logic [INDEX_WIDTH-1:0] ni;
      logic [FIELD_WIDTH-1:0] s;
      logic [FIELD_WIDTH-1:0] t;
   } held_vertex_type;

endpackage

`default_nettype wire

>>> src/sfte_tex_scale.sv
// Texture coordinate scaling: signed coordinate times Q1.23 reciprocal, saturated.
`default_nettype none

module sfte_tex_scale (
   input  wire logic [sfte_pkg::FIELD_WIDTH-1:0] coord,
   input  wire logic [sfte_pkg::INV_WIDTH-1:0]   inv,
   output logic      [sfte_pkg::TEX_WIDTH-1:0]   scaled
);

   logic signed [sfte_pkg::PROD_WIDTH-1:0] coord_ext;
   logic signed [sfte_pkg::PROD_WIDTH-1:0] inv_ext;
   logic signed [sfte_pkg::PROD_WIDTH-1:0] prod;
   logic                                   in_range;

   assign coord_ext = {{(sfte_pkg::PROD_WIDTH-sfte_pkg::FIELD_WIDTH){coord[sfte_pkg::FIELD_WIDTH-1]}},
                       coord};
   assign inv_ext   = {{(sfte_pkg::PROD_WIDTH-sfte_pkg::INV_WIDTH){1'b0}}, inv};
   assign prod      = coord_ext * inv_ext;

   // top bits must all match the sign of the 39-bit result
   assign in_range = (prod[sfte_pkg::PROD_WIDTH-1:sfte_pkg::TEX_WIDTH-1] == '0) ||
                     (prod[sfte_pkg::PROD_WIDTH-1:sfte_pkg::TEX_WIDTH-1] == '1);

   always_comb begin
      if (in_range) begin
         scaled = prod[sfte_pkg::TEX_WIDTH-1:0];
      end else if (prod[sfte_pkg::PROD_WIDTH-1]) begin
         scaled = sfte_pkg::TEX_MIN;
      end else begin
         scaled = sfte_pkg::TEX_MAX;
      end
   end

endmodule

`default_nettype wire

>>> src/strip_fan_triangle_expander.sv
// Flow: a vertex that closes a triangle loads the triangle buffer, whose corners then pass
//   in order through the single result register, which sends one corner a cycle while the
//   result side is not stalled; other records do not load the triangle buffer.
// A new record is taken in the cycle the last pending corner moves to the result register.
// Reset: synchronous, active high; clears primitive length, position, fan flag and slot
//   counter and the valid flags, and loads the register defaults (counts zero, reciprocals 131072).
`default_nettype none

module strip_fan_triangle_expander #(
   parameter int SLOT_WIDTH = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [sfte_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [sfte_pkg::INV_WIDTH-1:0]        csr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_action,
   input  wire logic [sfte_pkg::FIELD_WIDTH-1:0]      req_prim_count,
   input  wire logic [sfte_pkg::FIELD_WIDTH-1:0]      req_vert_index,
   input  wire logic [sfte_pkg::FIELD_WIDTH-1:0]      req_norm_index,
   input  wire logic [sfte_pkg::FIELD_WIDTH-1:0]      req_tex_s,
   input  wire logic [sfte_pkg::FIELD_WIDTH-1:0]      req_tex_t,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [sfte_pkg::INDEX_WIDTH-1:0]      rsp_out_vert_index,
   output logic      [sfte_pkg::INDEX_WIDTH-1:0]      rsp_out_norm_index,
   output logic      [sfte_pkg::TEX_WIDTH-1:0]        rsp_tex_u,
   output logic      [sfte_pkg::TEX_WIDTH-1:0]        rsp_tex_v,
   output logic      [SLOT_WIDTH-1:0]                 rsp_vertex_slot,
   output logic                                       rsp_tri_end
);

   localparam logic [SLOT_WIDTH-1:0] SLOT_MAX = '1;

   function automatic logic [SLOT_WIDTH-1:0] slot_step(input logic [SLOT_WIDTH-1:0] v);
      return (v == SLOT_MAX) ? v : v + SLOT_WIDTH'(1);
   endfunction

   function automatic logic [sfte_pkg::INDEX_WIDTH-1:0] clamp_index(
      input logic [sfte_pkg::FIELD_WIDTH-1:0] idx,
      input logic [sfte_pkg::FIELD_WIDTH-1:0] count
   );
      if (idx[sfte_pkg::FIELD_WIDTH-1] || (idx >= count)) begin
         return '0;
      end
      return idx[sfte_pkg::INDEX_WIDTH-1:0];
   endfunction

   // configuration
   logic [sfte_pkg::FIELD_WIDTH-1:0] vertex_count_ff;
   logic [sfte_pkg::FIELD_WIDTH-1:0] normal_count_ff;
   logic [sfte_pkg::INV_WIDTH-1:0]   inv_width_ff;
   logic [sfte_pkg::INV_WIDTH-1:0]   inv_height_ff;

   // primitive state
   sfte_pkg::held_vertex_type        held_ff [3];
   sfte_pkg::held_vertex_type        held_in [3];
   logic [sfte_pkg::FIELD_WIDTH-1:0] len_ff, len_in;
   logic [sfte_pkg::FIELD_WIDTH-1:0] pos_ff, pos_in;
   logic                             fan_ff, fan_in;
   logic [SLOT_WIDTH-1:0]            slot_ff, slot_in;

   // triangle buffer
   logic                             tri_valid_ff, tri_valid_in;
   logic [1:0]                       corner_ff, corner_in;
   sfte_pkg::held_vertex_type        tri_corner_ff [3];
   sfte_pkg::held_vertex_type        tri_corner_in [3];
   logic [SLOT_WIDTH-1:0]            tri_slot_ff [3];
   logic [SLOT_WIDTH-1:0]            tri_slot_in [3];
   logic                             tri_load;

   // result register
   logic                             rsp_valid_ff;
   logic [sfte_pkg::INDEX_WIDTH-1:0] rsp_vi_ff, rsp_ni_ff;
   logic [sfte_pkg::TEX_WIDTH-1:0]   rsp_u_ff, rsp_v_ff;
   logic [SLOT_WIDTH-1:0]            rsp_slot_ff;
   logic                             rsp_end_ff;

   logic                             accept;
   logic                             out_free;
   logic                             tri_advance;
   logic                             tri_last;
   sfte_pkg::held_vertex_type        nv;
   sfte_pkg::held_vertex_type        sel_corner;
   logic [SLOT_WIDTH-1:0]            sel_slot;
   logic [sfte_pkg::FIELD_WIDTH-1:0] pos_next;
   logic [SLOT_WIDTH-1:0]            slot1, slot2;
   logic [sfte_pkg::TEX_WIDTH-1:0]   scaled_u, scaled_v;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign tri_advance = tri_valid_ff && out_free;
   assign tri_last    = tri_advance && (corner_ff == sfte_pkg::CORNER_LAST);
   assign req_stall   = tri_valid_ff && !tri_last;
   assign accept      = req_valid && !req_stall;

   assign nv.vi = clamp_index(req_vert_index, vertex_count_ff);
   assign nv.ni = clamp_index(req_norm_index, normal_count_ff);
   assign nv.s  = req_tex_s;
   assign nv.t  = req_tex_t;

   assign pos_next = pos_ff + sfte_pkg::FIELD_WIDTH'(1);
   assign slot1    = slot_step(slot_ff);
   assign slot2    = slot_step(slot1);

   always_comb begin
      held_in       = held_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      fan_in        = fan_ff;
      slot_in       = slot_ff;
      tri_load      = 1'b0;
      tri_corner_in = tri_corner_ff;
      tri_slot_in   = tri_slot_ff;
      if (accept) begin
         if (req_action == sfte_pkg::ACTION_HEADER) begin
            pos_in = '0;
            if (req_prim_count == '0) begin
               len_in  = '0;
               fan_in  = 1'b0;
               slot_in = '0;
            end else if (req_prim_count[sfte_pkg::FIELD_WIDTH-1]) begin
               len_in = -req_prim_count;
               fan_in = 1'b1;
            end else begin
               len_in = req_prim_count;
               fan_in = 1'b0;
            end
         end else if (pos_ff < len_ff) begin
            if (fan_ff && (pos_ff == '0)) begin
               held_in[0] = nv;
            end else begin
               if (!fan_ff) begin
                  held_in[0] = held_ff[1];
               end
               held_in[1] = held_ff[2];
               held_in[2] = nv;
            end
            pos_in = pos_next;
            if (pos_next >= sfte_pkg::FIELD_WIDTH'(3)) begin
               tri_load = 1'b1;
               // odd strip triangles swap the first two corners
               if (!fan_ff && !pos_next[0]) begin
                  tri_corner_in[0] = held_in[1];
                  tri_corner_in[1] = held_in[0];
               end else begin
                  tri_corner_in[0] = held_in[0];
                  tri_corner_in[1] = held_in[1];
               end
               tri_corner_in[2] = held_in[2];
               tri_slot_in[0]   = slot_ff;
               tri_slot_in[1]   = slot1;
               tri_slot_in[2]   = slot2;
               slot_in          = slot_step(slot2);
            end
         end
      end
   end

   always_comb begin
      if (tri_load) begin
         tri_valid_in = 1'b1;
         corner_in    = sfte_pkg::CORNER_FIRST;
      end else if (tri_last) begin
         tri_valid_in = 1'b0;
         corner_in    = sfte_pkg::CORNER_FIRST;
      end else if (tri_advance) begin
         tri_valid_in = 1'b1;
         corner_in    = corner_ff + 2'd1;
      end else begin
         tri_valid_in = tri_valid_ff;
         corner_in    = corner_ff;
      end
   end

   always_comb begin
      unique case (corner_ff)
         sfte_pkg::CORNER_FIRST: begin
            sel_corner = tri_corner_ff[0];
            sel_slot   = tri_slot_ff[0];
         end
         sfte_pkg::CORNER_SECOND: begin
            sel_corner = tri_corner_ff[1];
            sel_slot   = tri_slot_ff[1];
         end
         default: begin
            sel_corner = tri_corner_ff[2];
            sel_slot   = tri_slot_ff[2];
         end
      endcase
   end

   sfte_tex_scale u_scale_u (
      .coord  (sel_corner.s),
      .inv    (inv_width_ff),
      .scaled (scaled_u)
   );

   sfte_tex_scale u_scale_v (
      .coord  (sel_corner.t),
      .inv    (inv_height_ff),
      .scaled (scaled_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         normal_count_ff <= '0;
         inv_width_ff    <= sfte_pkg::INV_TEX_RESET;
         inv_height_ff   <= sfte_pkg::INV_TEX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sfte_pkg::CSR_VERTEX_COUNT:  vertex_count_ff <= csr_data[sfte_pkg::FIELD_WIDTH-1:0];
            sfte_pkg::CSR_NORMAL_COUNT:  normal_count_ff <= csr_data[sfte_pkg::FIELD_WIDTH-1:0];
            sfte_pkg::CSR_INV_TEX_WIDTH: inv_width_ff    <= csr_data;
            default:                     inv_height_ff   <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pos_ff       <= '0;
         fan_ff       <= 1'b0;
         slot_ff      <= '0;
         tri_valid_ff <= 1'b0;
         corner_ff    <= sfte_pkg::CORNER_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         fan_ff       <= fan_in;
         slot_ff      <= slot_in;
         tri_valid_ff <= tri_valid_in;
         corner_ff    <= corner_in;
         if (out_free) begin
            rsp_valid_ff <= tri_valid_ff;
         end
      end
   end

   // payload: held vertices are always written before a triangle reads them
   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      tri_corner_ff <= tri_corner_in;
      tri_slot_ff <= tri_slot_in;
      if (tri_advance) begin
         rsp_vi_ff   <= sel_corner.vi;
         rsp_ni_ff   <= sel_corner.ni;
         rsp_u_ff    <= scaled_u;
         rsp_v_ff    <= scaled_v;
         rsp_slot_ff <= sel_slot;
         rsp_end_ff  <= (corner_ff == sfte_pkg::CORNER_LAST);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_vert_index = rsp_vi_ff;
   assign rsp_out_norm_index = rsp_ni_ff;
   assign rsp_tex_u          = rsp_u_ff;
   assign rsp_tex_v          = rsp_v_ff;
   assign rsp_vertex_slot    = rsp_slot_ff;
   assign rsp_tri_end        = rsp_end_ff;

   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      corner_ff != 2'd3)
      else $error("corner select out of range");

   a_pos_within_len: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff)
      else $error("primitive position beyond its length");

   a_tri_held: assert property (@(posedge clock) disable iff (reset)
      tri_valid_ff && !tri_advance |=> tri_valid_ff && $stable(corner_ff))
      else $error("pending triangle lost while result stalled");

   a_tri_end_last: assert property (@(posedge clock) disable iff (reset)
      tri_advance |=> rsp_valid && (rsp_tri_end == ($past(corner_ff) == sfte_pkg::CORNER_LAST)))
      else $error("triangle end flag does not match corner");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      tri_load |-> !tri_valid_ff || tri_last)
      else $error("triangle buffer overwritten");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the strip/fan triangle expander.
`timescale 1ns / 100ps

localparam int SLOT_W = 24;

typedef struct {
   logic        action;
   logic [15:0] prim_count;
   logic [15:0] vert_index;
   logic [15:0] norm_index;
   logic [15:0] tex_s;
   logic [15:0] tex_t;
} record_type;

typedef struct {
   logic [sfte_pkg::INDEX_WIDTH-1:0] vert_index;
   logic [sfte_pkg::INDEX_WIDTH-1:0] norm_index;
   logic [sfte_pkg::TEX_WIDTH-1:0]   tex_u;
   logic [sfte_pkg::TEX_WIDTH-1:0]   tex_v;
   logic [SLOT_W-1:0]                vertex_slot;
   logic                             tri_end;
} corner_type;

class corner_predictor;
   logic [15:0]                    vert_count;
   logic [15:0]                    norm_count;
   logic [sfte_pkg::INV_WIDTH-1:0] inv_width;
   logic [sfte_pkg::INV_WIDTH-1:0] inv_height;
   sfte_pkg::held_vertex_type      held [3];
   int                             prim_len;
   int                             prim_pos;
   bit                             fan;
   logic [SLOT_W-1:0]              slot;
   corner_type                     expected_corners [$];
   int                             errors;
   int                             corners_checked;

   function new();
      vert_count = '0;
      norm_count = '0;
      inv_width = sfte_pkg::INV_TEX_RESET;
      inv_height = sfte_pkg::INV_TEX_RESET;
      foreach (held[i]) held[i] = '0;
      prim_len = 0;
      prim_pos = 0;
      fan = 1'b0;
      slot = '0;
      errors = 0;
      corners_checked = 0;
   endfunction

   function void set_register(logic [sfte_pkg::CSR_INDEX_WIDTH-1:0] idx,
                              logic [sfte_pkg::INV_WIDTH-1:0] data);
      case (idx)
         sfte_pkg::CSR_VERTEX_COUNT:   vert_count = data[15:0];
         sfte_pkg::CSR_NORMAL_COUNT:   norm_count = data[15:0];
         sfte_pkg::CSR_INV_TEX_WIDTH:  inv_width = data;
         sfte_pkg::CSR_INV_TEX_HEIGHT: inv_height = data;
         default: ;
      endcase
   endfunction

   function logic [sfte_pkg::INDEX_WIDTH-1:0] clamp_index(logic [15:0] idx, logic [15:0] limit);
      if (idx[15] || idx >= limit) return '0;
      return idx[sfte_pkg::INDEX_WIDTH-1:0];
   endfunction

   // exact product, saturated to the signed 39-bit range
   function logic [sfte_pkg::TEX_WIDTH-1:0] scale_coord(logic [15:0] coord,
                                                        logic [sfte_pkg::INV_WIDTH-1:0] inv);
      longint prod;
      prod = longint'($signed(coord)) * longint'({1'b0, inv});
      if (prod > 64'sd274877906943) prod = 64'sd274877906943;
      if (prod < -64'sd274877906944) prod = -64'sd274877906944;
      return prod[sfte_pkg::TEX_WIDTH-1:0];
   endfunction

   function void push_corner(sfte_pkg::held_vertex_type hv, bit last);
      corner_type c;
      c.vert_index = hv.vi;
      c.norm_index = hv.ni;
      c.tex_u = scale_coord(hv.s, inv_width);
      c.tex_v = scale_coord(hv.t, inv_height);
      c.vertex_slot = slot;
      c.tri_end = last;
      expected_corners.push_back(c);
      if (slot != {SLOT_W{1'b1}}) slot = slot + 1'b1;
   endfunction

   // Returns 0 when the record is a stray vertex the block ignores.
   function bit take_record(record_type rec);
      sfte_pkg::held_vertex_type nv;
      if (rec.action == sfte_pkg::ACTION_HEADER) begin
         prim_pos = 0;
         if (rec.prim_count == 16'd0) begin
            prim_len = 0;
            fan = 1'b0;
            slot = '0;
         end else if (rec.prim_count[15]) begin
            prim_len = -int'($signed(rec.prim_count));
            fan = 1'b1;
         end else begin
            prim_len = int'(rec.prim_count);
            fan = 1'b0;
         end
         return 1'b1;
      end
      if (prim_pos >= prim_len) return 1'b0;
      nv.vi = clamp_index(rec.vert_index, vert_count);
      nv.ni = clamp_index(rec.norm_index, norm_count);
      nv.s = rec.tex_s;
      nv.t = rec.tex_t;
      if (fan && prim_pos == 0) begin
         held[0] = nv;
      end else begin
         if (!fan) held[0] = held[1];
         held[1] = held[2];
         held[2] = nv;
      end
      prim_pos++;
      if (prim_pos < 3) return 1'b1;
      // odd strip triangles swap their first two corners
      if (!fan && prim_pos % 2 == 0) begin
         push_corner(held[1], 1'b0);
         push_corner(held[0], 1'b0);
      end else begin
         push_corner(held[0], 1'b0);
         push_corner(held[1], 1'b0);
      end
      push_corner(held[2], 1'b1);
      return 1'b1;
   endfunction

   function void check_corner(corner_type got);
      corner_type exp;
      if (expected_corners.size() == 0) begin
         $error("corner with no expectation: slot %0d", got.vertex_slot);
         errors++;
         return;
      end
      exp = expected_corners.pop_front();
      corners_checked++;
      if (got.vert_index !== exp.vert_index) begin
         $error("out_vert_index: expected %0d, got %0d", exp.vert_index, got.vert_index);
         errors++;
      end
      if (got.norm_index !== exp.norm_index) begin
         $error("out_norm_index: expected %0d, got %0d", exp.norm_index, got.norm_index);
         errors++;
      end
      if (got.tex_u !== exp.tex_u) begin
         $error("tex_u: expected %0d, got %0d", $signed(exp.tex_u), $signed(got.tex_u));
         errors++;
      end
      if (got.tex_v !== exp.tex_v) begin
         $error("tex_v: expected %0d, got %0d", $signed(exp.tex_v), $signed(got.tex_v));
         errors++;
      end
      if (got.vertex_slot !== exp.vertex_slot) begin
         $error("vertex_slot: expected %0d, got %0d", exp.vertex_slot, got.vertex_slot);
         errors++;
      end
      if (got.tri_end !== exp.tri_end) begin
         $error("tri_end: expected %0d, got %0d", exp.tri_end, got.tri_end);
         errors++;
      end
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT = 400000;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_write_enable;
   logic [sfte_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [sfte_pkg::INV_WIDTH-1:0]       csr_data;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_action;
   logic [sfte_pkg::FIELD_WIDTH-1:0]     req_prim_count;
   logic [sfte_pkg::FIELD_WIDTH-1:0]     req_vert_index;
   logic [sfte_pkg::FIELD_WIDTH-1:0]     req_norm_index;
   logic [sfte_pkg::FIELD_WIDTH-1:0]     req_tex_s;
   logic [sfte_pkg::FIELD_WIDTH-1:0]     req_tex_t;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [sfte_pkg::INDEX_WIDTH-1:0]     rsp_out_vert_index;
   logic [sfte_pkg::INDEX_WIDTH-1:0]     rsp_out_norm_index;
   logic [sfte_pkg::TEX_WIDTH-1:0]       rsp_tex_u;
   logic [sfte_pkg::TEX_WIDTH-1:0]       rsp_tex_v;
   logic [SLOT_W-1:0]                    rsp_vertex_slot;
   logic                                 rsp_tri_end;

   corner_predictor sb;
   int  cycle_count;
   int  records_used;
   int  settings_used;
   int  stall_hold;
   bit  no_idle;

   strip_fan_triangle_expander #(
      .SLOT_WIDTH(SLOT_W)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_prim_count     (req_prim_count),
      .req_vert_index     (req_vert_index),
      .req_norm_index     (req_norm_index),
      .req_tex_s          (req_tex_s),
      .req_tex_t          (req_tex_t),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_vert_index (rsp_out_vert_index),
      .rsp_out_norm_index (rsp_out_norm_index),
      .rsp_tex_u          (rsp_tex_u),
      .rsp_tex_v          (rsp_tex_v),
      .rsp_vertex_slot    (rsp_vertex_slot),
      .rsp_tri_end        (rsp_tri_end)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // result side stall: mostly short runs, now and then a long one
   always @(negedge clock) begin : stall_gen
      int r;
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_stall <= 1'b0;
            stall_hold = $urandom_range(0, 6);
         end else if (r < 93) begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(9, 29);
         end
      end
   end

   always @(posedge clock) begin : corner_monitor
      corner_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.vert_index = rsp_out_vert_index;
         got.norm_index = rsp_out_norm_index;
         got.tex_u = rsp_tex_u;
         got.tex_v = rsp_tex_v;
         got.vertex_slot = rsp_vertex_slot;
         got.tri_end = rsp_tri_end;
         sb.check_corner(got);
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [15:0] pick_index(logic [15:0] limit);
      case ($urandom_range(0, 5))
         0, 1:    return 16'($urandom);
         2:       return limit;
         3:       return limit - 16'd1;
         default: return 16'($urandom_range(0, int'(limit) + 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_record(input logic act, input logic [15:0] pc, vi, ni, s, t);
      record_type rec;
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_prim_count <= pc;
      req_vert_index <= vi;
      req_norm_index <= ni;
      req_tex_s <= s;
      req_tex_t <= t;
      do @(posedge clock); while (req_stall);
      rec.action = act;
      rec.prim_count = pc;
      rec.vert_index = vi;
      rec.norm_index = ni;
      rec.tex_s = s;
      rec.tex_t = t;
      if (sb.take_record(rec)) records_used++;
   endtask

   task automatic send_header(input logic [15:0] pc);
      send_record(sfte_pkg::ACTION_HEADER, pc, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
   endtask

   task automatic send_vertex(input logic [15:0] vi, ni, s, t);
      send_record(sfte_pkg::ACTION_VERTEX, 16'($urandom), vi, ni, s, t);
   endtask

   task automatic send_any_vertex();
      send_vertex(pick_index(sb.vert_count), pick_index(sb.norm_count), pick_coord(),
                  pick_coord());
   endtask

   // drop valid, then hold until every expected corner has been transferred
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_corners.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] vc, nc, input logic [23:0] iw, ih);
      logic [sfte_pkg::CSR_INDEX_WIDTH-1:0] ids [4];
      logic [sfte_pkg::INV_WIDTH-1:0] vals [4];
      ids = '{sfte_pkg::CSR_VERTEX_COUNT, sfte_pkg::CSR_NORMAL_COUNT,
              sfte_pkg::CSR_INV_TEX_WIDTH, sfte_pkg::CSR_INV_TEX_HEIGHT};
      vals = '{{8'd0, vc}, {8'd0, nc}, iw, ih};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= ids[i];
         csr_data <= vals[i];
         @(posedge clock);
         sb.set_register(ids[i], vals[i]);
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      int goal;
      int len;
      int nverts;
      int r;
      bit is_fan;
      goal = records_used + count;
      while (records_used < goal) begin
         r = $urandom_range(0, 19);
         if (r == 0) begin
            send_record(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
         end else if (r == 1) begin
            send_header(16'd0);
         end else if (r == 2) begin
            wait_for_drain();
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            is_fan = 1'($urandom);
            send_header(is_fan ? 16'(-len) : 16'(len));
            nverts = len;
            r = $urandom_range(0, 9);
            // cut some primitives short, overrun others by one stray vertex
            if (r == 0) nverts = $urandom_range(0, len - 1);
            else if (r == 1) nverts = len + 1;
            repeat (nverts) send_any_vertex();
         end
      end
   endtask

   initial begin
      sb = new();
      cycle_count = 0;
      records_used = 0;
      settings_used = 0;
      stall_hold = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = sfte_pkg::CSR_VERTEX_COUNT;
      csr_data = '0;
      req_valid = 1'b0;
      req_action = sfte_pkg::ACTION_HEADER;
      req_prim_count = '0;
      req_vert_index = '0;
      req_norm_index = '0;
      req_tex_s = '0;
      req_tex_t = '0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults after reset
      run_random(20);

      wait_for_drain();
      write_settings(16'd100, 16'd50, 24'h800000, 24'hFFFFFF);
      send_header(16'd0);
      send_vertex(16'd5, 16'd5, 16'd1, 16'd1);
      send_header(16'd3);
      send_vertex(16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_vertex(16'd99, 16'd49, 16'd0, 16'hFFFF);
      send_header(-16'sd4);
      send_vertex(16'd100, 16'd50, 16'h7FFF, 16'h7FFF);
      repeat (3) send_any_vertex();
      send_header(16'd4);
      repeat (5) send_any_vertex();
      send_header(16'd2);
      send_any_vertex();
      send_header(16'h8000);
      repeat (3) send_any_vertex();
      send_header(16'd1);
      send_any_vertex();

      wait_for_drain();
      write_settings(16'hFFFF, 16'hFFFF, 24'd0, 24'd0);
      no_idle = 1'b1;
      run_random(24);
      no_idle = 1'b0;

      wait_for_drain();
      write_settings(16'd0, 16'd0, sfte_pkg::INV_TEX_RESET, 24'h800000);
      run_random(24);

      wait_for_drain();
      write_settings(16'($urandom_range(1, 40000)), 16'($urandom_range(1, 40000)),
                     24'($urandom), 24'($urandom));
      run_random(24);

      wait_for_drain();
      write_settings(16'h8000, 16'd1, 24'hFFFFFF, 24'd1);
      run_random(24);

      wait_for_drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d records over %0d register settings plus reset defaults;",
               records_used, settings_used);
      $display("checked %0d triangle corners, %0d mismatches.", sb.corners_checked, sb.errors);
      if (sb.errors == 0 && sb.expected_corners.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
